// ===== rtl/core/brsc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brsc_pkg: shared types and constants
// Widths, opcodes and the cell record used by the box rest support checker.
// ----------------------------------------------------------------------------
package brsc_pkg;

  localparam int MaxBoxes  = 256;
  localparam int CoordBits = 12;
  localparam int EdgeBits  = CoordBits + 1;
  localparam int IdxBits   = $clog2(MaxBoxes);
  localparam int CntBits   = $clog2(MaxBoxes + 1);
  localparam int AreaBits  = 2 * EdgeBits + IdxBits;
  localparam int QBits     = 11;
  localparam int FracBits  = QBits;
  localparam logic [QBits-1:0] QOne = QBits'(1024);

  localparam logic [1:0] OpClear  = 2'd0;
  localparam logic [1:0] OpInsert = 2'd1;
  localparam logic [1:0] OpQuery  = 2'd2;

  // One stored box, upper corners already summed.
  typedef struct packed {
    logic [EdgeBits-1:0] x1;
    logic [EdgeBits-1:0] y1;
    logic [EdgeBits-1:0] x2;
    logic [EdgeBits-1:0] y2;
    logic [EdgeBits-1:0] z1;
    logic [EdgeBits-1:0] z2;
  } box_t;

  // Chain control: shift the ring one place, or append at the head.
  typedef struct packed {
    logic rotate;
    logic load;
  } chain_ctl_t;

endpackage

// ===== rtl/core/brsc_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brsc_cell: one slot of the box ring
// Holds one box and passes it to the next cell when the ring rotates.
// ----------------------------------------------------------------------------
module brsc_cell (
  input  logic                clk_i,
  input  brsc_pkg::chain_ctl_t ctl_i,
  input  brsc_pkg::box_t       prev_i,
  input  brsc_pkg::box_t       load_i,
  output brsc_pkg::box_t       box_o
);
  import brsc_pkg::*;

  box_t box_q, box_d;

  always_comb begin
    box_d = box_q;
    if (ctl_i.load) begin
      box_d = load_i;
    end else if (ctl_i.rotate) begin
      box_d = prev_i;
    end
  end

  always_ff @(posedge clk_i) begin
    box_q <= box_d;
  end

  assign box_o = box_q;
endmodule

// ===== rtl/core/brsc_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brsc_div: serial restoring divider
// Computes floor(area * 1024 / base) for area < base, one quotient bit a cycle.
// ----------------------------------------------------------------------------
module brsc_div (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start_i,
  input  logic [2*brsc_pkg::EdgeBits-1:0]    num_i,
  input  logic [2*brsc_pkg::EdgeBits-1:0]    den_i,
  output logic                               done_o,
  output logic [brsc_pkg::FracBits-1:0]      quo_o
);
  import brsc_pkg::*;

  localparam int RemBits = 2 * EdgeBits + 1;

  logic [RemBits-1:0]    rem_q, rem_d, shl;
  logic [2*EdgeBits-1:0] den_q, den_d;
  logic [FracBits-1:0]   quo_q, quo_d;
  logic [3:0]            cnt_q, cnt_d;
  logic                  busy_q, busy_d, done_q, done_d;

  always_comb begin
    rem_d  = rem_q;
    den_d  = den_q;
    quo_d  = quo_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    shl    = {rem_q[RemBits-2:0], 1'b0};
    if (start_i) begin
      rem_d  = {1'b0, num_i};
      den_d  = den_i;
      quo_d  = '0;
      cnt_d  = 4'd10;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (shl >= {1'b0, den_q}) begin
        rem_d = shl - {1'b0, den_q};
        quo_d = {quo_q[FracBits-2:0], 1'b1};
      end else begin
        rem_d = shl;
        quo_d = {quo_q[FracBits-2:0], 1'b0};
      end
      if (cnt_q == 4'd1) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
      cnt_d = cnt_q - 4'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    den_q <= den_d;
    quo_q <= quo_d;
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;
endmodule

// ===== rtl/core/box_rest_support_check_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// box_rest_support_check_top: pallet box rest height and support checker
// Keeps placed boxes in a ring of cells and answers rest/support queries.
// ----------------------------------------------------------------------------
// Usage: one item enters on the s_axis channel (opcode in tuser, box fields in
// tdata) and exactly one result leaves on m_axis. For a clear or an insert the
// result passes through StOut into the output register. A query rotates the ring of
// MaxBoxes cells one full turn to find the rest height, then a second full
// turn for the overlap test and the support sum. When a division is needed, a
// serial divider follows the second turn before the result is registered.
// The query time does not depend on how full the table is; the ring length
// sets it. Only cells below the box count take part.
// One item is worked on at a time: s_axis_tready is low from acceptance until
// the result is taken, and the next item can be accepted in the cycle after the
// result transfer. The result is held in an output register while
// m_axis_tready is low. Reset empties the table at once; the cell contents
// need no clearing since only counted entries are read.
// ----------------------------------------------------------------------------
module box_rest_support_check_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // corner_x, corner_y, base_z, size_x, size_y, size_z, support_req
  input  logic [87:0] s_axis_tdata,
  // opcode
  input  logic [1:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // rest_height, overlap_free, support_fraction, centre_supported, accepted,
  // stored_count, table_full
  output logic [39:0] m_axis_tdata
);
  import brsc_pkg::*;

  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StPass1 = 3'd1;
  localparam logic [2:0] StPass2 = 3'd2;
  localparam logic [2:0] StDiv = 3'd3;
  localparam logic [2:0] StOut = 3'd4;
  localparam int AccBits = AreaBits;

  logic [2:0] st_q, st_d;
  logic [CntBits-1:0] cnt_q, cnt_d, step_q, step_d;
  logic [1:0] op_q;
  logic [CoordBits-1:0] qx_q, qy_q, qdx_q, qdy_q, qdz_q;
  logic [QBits-1:0] req_q;
  logic [EdgeBits-1:0] rest_q, rest_d;
  logic free_q, free_d, cen_q, cen_d, full_q, full_d;
  logic [AccBits-1:0] area_q, area_d;
  logic [FracBits-1:0] frac_q, frac_d;
  logic ovalid_q, ovalid_d;
  logic [39:0] odata_q, odata_d;

  chain_ctl_t ctl;
  box_t cells [MaxBoxes];
  box_t newbox;

  // Ring of cells: cell 0 takes new boxes, the last cell feeds cell 0.
  for (genvar g = 0; g < MaxBoxes; g++) begin : g_cell
    brsc_cell u_cell (
      .clk_i (clk_i),
      .ctl_i (ctl),
      .prev_i(cells[(g + MaxBoxes - 1) % MaxBoxes]),
      .load_i(g == 0 ? newbox : cells[(g + MaxBoxes - 1) % MaxBoxes]),
      .box_o (cells[g])
    );
  end

  // Inserts shift the ring down one place and write at cell 0. Entry k
  // therefore sits at cell count-1-k, and a full turn restores the order.
  always_comb begin
    newbox.x1 = {1'b0, s_axis_tdata[11:0]};
    newbox.y1 = {1'b0, s_axis_tdata[23:12]};
    newbox.z1 = {1'b0, s_axis_tdata[35:24]};
    newbox.x2 = {1'b0, s_axis_tdata[11:0]} + {1'b0, s_axis_tdata[47:36]};
    newbox.y2 = {1'b0, s_axis_tdata[23:12]} + {1'b0, s_axis_tdata[59:48]};
    newbox.z2 = {1'b0, s_axis_tdata[35:24]} + {1'b0, s_axis_tdata[71:60]};
  end

  logic acc_in, ins_ok;
  assign s_axis_tready = (st_q == StIdle) && !ovalid_q;
  assign acc_in = s_axis_tvalid && s_axis_tready;
  assign ins_ok = acc_in && s_axis_tuser == OpInsert && cnt_q != CntBits'(MaxBoxes);

  logic pass;
  assign pass = (st_q == StPass1) || (st_q == StPass2);
  assign ctl.load   = ins_ok;
  assign ctl.rotate = pass;

  // Evaluate the box leaving the last cell. Entry 0 reaches it after
  // MaxBoxes - count steps of a turn, so the last count steps carry the
  // stored boxes.
  box_t b;
  logic [EdgeBits-1:0] qx2, qy2, ox1, oy1, ox2, oy2;
  logic [EdgeBits:0] rz2, cx2, cy2;
  logic live, fmeet, zmeet;
  logic [2*EdgeBits-1:0] oarea, base;
  logic div_start, div_done;
  logic [FracBits-1:0] quo;

  always_comb begin
    b     = cells[MaxBoxes-1];
    qx2   = {1'b0, qx_q} + {1'b0, qdx_q};
    qy2   = {1'b0, qy_q} + {1'b0, qdy_q};
    rz2   = {1'b0, rest_q} + {2'b0, qdz_q};
    live  = ({1'b0, step_q} + {1'b0, cnt_q}) >= (CntBits + 1)'(MaxBoxes);
    fmeet = ((b.x2 < qx2 ? b.x2 : qx2) > (b.x1 > {1'b0, qx_q} ? b.x1 : {1'b0, qx_q}))
         && ((b.y2 < qy2 ? b.y2 : qy2) > (b.y1 > {1'b0, qy_q} ? b.y1 : {1'b0, qy_q}));
    zmeet = ({1'b0, b.z2} < rz2 ? {1'b0, b.z2} : rz2)
          > {1'b0, (b.z1 > rest_q ? b.z1 : rest_q)};
    ox1   = b.x1 > {1'b0, qx_q} ? b.x1 : {1'b0, qx_q};
    oy1   = b.y1 > {1'b0, qy_q} ? b.y1 : {1'b0, qy_q};
    ox2   = b.x2 < qx2 ? b.x2 : qx2;
    oy2   = b.y2 < qy2 ? b.y2 : qy2;
    oarea = (ox2 - ox1) * (oy2 - oy1);
    cx2   = {1'b0, qx_q, 1'b0} + {2'b0, qdx_q};
    cy2   = {1'b0, qy_q, 1'b0} + {2'b0, qdy_q};
    base  = {1'b0, qdx_q} * {1'b0, qdy_q};
  end

  // The divider starts in the last step of the second turn, so it takes the
  // sum that includes that step.
  brsc_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(div_start),
    .num_i  (area_d[2*EdgeBits-1:0]),
    .den_i  (base),
    .done_o (div_done),
    .quo_o  (quo)
  );

  always_comb begin
    st_d      = st_q;
    cnt_d     = cnt_q;
    step_d    = step_q;
    rest_d    = rest_q;
    free_d    = free_q;
    cen_d     = cen_q;
    full_d    = full_q;
    area_d    = area_q;
    frac_d    = frac_q;
    ovalid_d  = ovalid_q;
    odata_d   = odata_q;
    div_start = 1'b0;
    if (ovalid_q && m_axis_tready) ovalid_d = 1'b0;
    unique case (st_q)
      StIdle: begin
        if (acc_in) begin
          rest_d = '0; free_d = 1'b0; cen_d = 1'b0; frac_d = '0; area_d = '0;
          full_d = 1'b0; step_d = '0;
          priority if (s_axis_tuser == OpClear) begin
            cnt_d = '0; st_d = StOut;
          end else if (s_axis_tuser == OpInsert) begin
            if (ins_ok) cnt_d = cnt_q + CntBits'(1);
            else full_d = 1'b1;
            st_d = StOut;
          end else if (s_axis_tuser == OpQuery) begin
            st_d = StPass1;
          end else begin
            st_d = StOut;
          end
        end
      end
      StPass1: begin
        if (live && fmeet && b.z2 > rest_q) rest_d = b.z2;
        step_d = step_q + CntBits'(1);
        if (step_q == CntBits'(MaxBoxes - 1)) begin
          step_d = '0; free_d = 1'b1; st_d = StPass2;
        end
      end
      StPass2: begin
        if (live && fmeet && zmeet) free_d = 1'b0;
        if (live && b.z2 == rest_q && ox2 > ox1 && oy2 > oy1) begin
          area_d = area_q + AccBits'(oarea);
          if (cx2 >= {ox1, 1'b0} && cx2 <= {ox2, 1'b0}
              && cy2 >= {oy1, 1'b0} && cy2 <= {oy2, 1'b0}) cen_d = 1'b1;
        end
        step_d = step_q + CntBits'(1);
        if (step_q == CntBits'(MaxBoxes - 1)) begin
          step_d = '0;
          if (rest_q == '0) begin
            frac_d = QOne; cen_d = 1'b1; st_d = StOut;
          end else if (base == '0) begin
            frac_d = '0; st_d = StOut;
          end else if (area_d >= AccBits'(base)) begin
            frac_d = QOne; st_d = StOut;
          end else begin
            div_start = 1'b1; st_d = StDiv;
          end
        end
      end
      StDiv: begin
        if (div_done) begin
          frac_d = quo; st_d = StOut;
        end
      end
      StOut: begin
        if (!ovalid_q) begin
          ovalid_d = 1'b1;
          odata_d = '0;
          odata_d[12:0]  = rest_q;
          odata_d[13]    = free_q;
          odata_d[24:14] = frac_q;
          odata_d[25]    = cen_q;
          odata_d[26]    = free_q && cen_q && frac_q >= req_q && op_q == OpQuery;
          odata_d[35:27] = 9'(cnt_q);
          odata_d[36]    = full_q;
          st_d = StIdle;
        end
      end
      default: st_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q     <= StIdle;
      cnt_q    <= '0;
      step_q   <= '0;
      ovalid_q <= 1'b0;
    end else begin
      st_q     <= st_d;
      cnt_q    <= cnt_d;
      step_q   <= step_d;
      ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc_in) begin
      op_q  <= s_axis_tuser;
      qx_q  <= s_axis_tdata[11:0];
      qy_q  <= s_axis_tdata[23:12];
      qdx_q <= s_axis_tdata[47:36];
      qdy_q <= s_axis_tdata[59:48];
      qdz_q <= s_axis_tdata[71:60];
      req_q <= s_axis_tdata[82:72];
    end
    rest_q  <= rest_d;
    free_q  <= free_d;
    cen_q   <= cen_d;
    full_q  <= full_d;
    area_q  <= area_d;
    frac_q  <= frac_d;
    odata_q <= odata_d;
  end

  assign m_axis_tvalid = ovalid_q;
  assign m_axis_tdata  = odata_q;

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntBits'(MaxBoxes)) else $error("box count above table size");
  a_busy_no_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q != StIdle |-> !s_axis_tready) else $error("ready while busy");
  a_frac_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ovalid_q |-> odata_q[24:14] <= QOne) else $error("support fraction above one");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ovalid_q && !m_axis_tready |=> ovalid_q && $stable(odata_q))
    else $error("result dropped under stall");
endmodule
